FILE: rtl/core/atps_pkg.sv
// shared types, codes and step tables of the alert tone pattern sequencer
// no dependencies
`timescale 1ns / 1ps

package atps_pkg;

  localparam int unsigned TICK_MS_DEF    = 10;
  localparam int unsigned COUNTER_HZ_DEF = 1000000;

  localparam int unsigned FreqW = 16;
  localparam int unsigned DurW  = 10;
  localparam int unsigned IdxW  = 3;

  localparam logic [FreqW-1:0] FREQ_DRY_HIGH_RST  = 16'd2500;
  localparam logic [FreqW-1:0] FREQ_DRY_LOW_RST   = 16'd1200;
  localparam logic [FreqW-1:0] FREQ_RAIN_RST      = 16'd2000;
  localparam logic [FreqW-1:0] FREQ_LINK_LOST_RST = 16'd1500;
  localparam logic [FreqW-1:0] RELOAD_MAX         = 16'hFFFF;

  typedef enum logic [1:0] {
    REQ_TICK     = 2'd0,
    REQ_SET_MODE = 2'd1,
    REQ_OFF      = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_DRY  = 2'd1,
    MODE_RAIN = 2'd2,
    MODE_LINK = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    CFG_ATTACHED       = 3'd0,
    CFG_FREQ_DRY_HIGH  = 3'd1,
    CFG_FREQ_DRY_LOW   = 3'd2,
    CFG_FREQ_RAIN      = 3'd3,
    CFG_FREQ_LINK_LOST = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    TONE_NONE     = 3'd0,
    TONE_DRY_HIGH = 3'd1,
    TONE_DRY_LOW  = 3'd2,
    TONE_RAIN     = 3'd3,
    TONE_LINK     = 3'd4
  } tone_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [1:0] new_mode;
  } in_item_t;

  typedef struct packed {
    logic              applied;
    logic              sound_on;
    logic [FreqW-1:0]  reload_value;
    logic [FreqW-1:0]  compare_value;
  } out_item_t;

  typedef struct packed {
    logic [DurW-1:0] dur;
    tone_e           tone;
    logic            on;
  } step_t;

  // number of steps in a mode's pattern
  function automatic logic [IdxW-1:0] step_count_f(mode_e mode);
    logic [IdxW-1:0] cnt;
    case (mode)
      MODE_DRY:  cnt = 3'd4;
      MODE_RAIN: cnt = 3'd6;
      MODE_LINK: cnt = 3'd2;
      default:   cnt = 3'd1;
    endcase
    return cnt;
  endfunction

  function automatic step_t step_f(mode_e mode, logic [IdxW-1:0] idx);
    step_t st;
    st = '{dur: '0, tone: TONE_NONE, on: 1'b0};
    case (mode)
      MODE_DRY: begin
        case (idx)
          3'd0:    st = '{dur: 10'd120, tone: TONE_DRY_HIGH, on: 1'b1};
          3'd1:    st = '{dur: 10'd60,  tone: TONE_NONE,     on: 1'b0};
          3'd2:    st = '{dur: 10'd120, tone: TONE_DRY_LOW,  on: 1'b1};
          default: st = '{dur: 10'd60,  tone: TONE_NONE,     on: 1'b0};
        endcase
      end
      MODE_RAIN: begin
        case (idx)
          3'd0, 3'd2, 3'd4: st = '{dur: 10'd80,  tone: TONE_RAIN, on: 1'b1};
          3'd5:             st = '{dur: 10'd400, tone: TONE_NONE, on: 1'b0};
          default:          st = '{dur: 10'd80,  tone: TONE_NONE, on: 1'b0};
        endcase
      end
      MODE_LINK: begin
        case (idx)
          3'd0:    st = '{dur: 10'd200, tone: TONE_LINK, on: 1'b1};
          default: st = '{dur: 10'd800, tone: TONE_NONE, on: 1'b0};
        endcase
      end
      default: st = '{dur: '0, tone: TONE_NONE, on: 1'b0};
    endcase
    return st;
  endfunction

endpackage

FILE: rtl/core/atps_div.sv
// restoring divider, one quotient bit per cycle: constant dividend over a 16-bit divisor
// depends on atps_pkg for the divisor width
`timescale 1ns / 1ps

module atps_div #(
  parameter int unsigned DIVIDEND = atps_pkg::COUNTER_HZ_DEF,
  parameter int unsigned QW       = $clog2(DIVIDEND + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [atps_pkg::FreqW-1:0]  divisor_i,
  output logic                        done_o,
  output logic [QW-1:0]               quotient_o
);

  localparam int unsigned CW = $clog2(QW + 1);
  localparam logic [QW-1:0] DividendBits = QW'(DIVIDEND);

  logic                       busy_q;
  logic                       done_q;
  logic [CW-1:0]              cnt_q;
  logic [atps_pkg::FreqW-1:0] div_q;
  logic [atps_pkg::FreqW-1:0] rem_q, rem_d;
  logic [QW-1:0]              quo_q, quo_d;
  logic [atps_pkg::FreqW:0]   trial;
  logic                       fits;

  always_comb begin
    trial = {rem_q, quo_q[QW-1]};
    fits  = trial >= {1'b0, div_q};
    rem_d = fits ? atps_pkg::FreqW'(trial - {1'b0, div_q}) : trial[atps_pkg::FreqW-1:0];
    quo_d = {quo_q[QW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      div_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(QW);
        div_q  <= divisor_i;
        rem_q  <= '0;
        quo_q  <= DividendBits;
      end else if (busy_q) begin
        rem_q <= rem_d;
        quo_q <= quo_d;
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: rtl/core/alert_tone_pattern_sequencer.sv
// top level of the alert tone pattern sequencer: step sequencing, config and item handshake
// depends on atps_pkg and atps_div
`timescale 1ns / 1ps

// Usage
// Input channel (in_valid_i / in_ready_o, in_item_i) takes one item: a tick of TICK_MS,
// a mode change or an immediate off. Output channel (out_valid_o / out_ready_i,
// out_item_o) returns exactly one result per item, in order.
// Config port: cfg_we_i writes cfg_wdata_i into the register selected by cfg_idx_i
// (0 attached, 1..4 tone frequencies); write only while the block is idle.
// Tone items: an item that starts a tone needs COUNTER_HZ / freq, computed by a shared
// restoring divider at one quotient bit per cycle; the result then passes the result
// register and the output register before output valid rises.
// Any other item goes straight to the result register and then to the output register.
// Flow: one item at a time; in_ready_o is high only while the sequencer is idle,
// so a new item is taken only after the last result has moved into the output register.
// The output sits in its own register, so the next item is accepted and worked on
// while a finished result still waits; if the receiver stalls, the block holds the
// following result internally and then stops accepting.
// Reset: mode off, step index and remaining time zero, attached set, tone frequencies
// at 2500, 1200, 2000 and 1500 Hz, no result pending.

module alert_tone_pattern_sequencer #(
  parameter int unsigned TICK_MS    = atps_pkg::TICK_MS_DEF,
  parameter int unsigned COUNTER_HZ = atps_pkg::COUNTER_HZ_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  atps_pkg::in_item_t          in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output atps_pkg::out_item_t         out_item_o,
  input  logic                        cfg_we_i,
  input  logic [2:0]                  cfg_idx_i,
  input  logic [atps_pkg::FreqW-1:0]  cfg_wdata_i
);

  localparam int unsigned QuotW = $clog2(COUNTER_HZ + 1);
  localparam int unsigned ArrW  = (QuotW > atps_pkg::FreqW) ? QuotW : atps_pkg::FreqW + 1;
  localparam logic [atps_pkg::DurW-1:0] TickMs = atps_pkg::DurW'(TICK_MS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e                       state_q;
  logic                         attached_q;
  logic [atps_pkg::FreqW-1:0]   freq_dry_high_q, freq_dry_low_q, freq_rain_q, freq_link_q;
  atps_pkg::mode_e              mode_q, mode_d;
  logic [atps_pkg::IdxW-1:0]    idx_q, idx_d;
  logic [atps_pkg::DurW-1:0]    rem_q, rem_d;
  atps_pkg::out_item_t          res_q, res_d;
  atps_pkg::out_item_t          out_q;
  logic                         out_valid_q;

  logic                         accept;
  logic                         load_out;
  logic                         need_div;
  logic [atps_pkg::IdxW-1:0]    step_cnt;
  logic [atps_pkg::IdxW-1:0]    idx_eff;
  logic [atps_pkg::IdxW-1:0]    idx_next;
  atps_pkg::step_t              step;
  logic [atps_pkg::FreqW-1:0]   freq;
  logic [atps_pkg::DurW-1:0]    rem_load;
  atps_pkg::mode_e              req_mode;

  logic                         div_done;
  logic [QuotW-1:0]             quotient;
  logic [ArrW-1:0]              quo_ext;
  logic [ArrW-1:0]              arr_wide;
  logic [atps_pkg::FreqW-1:0]   arr;
  logic [atps_pkg::FreqW:0]     half_sum;

  assign accept   = in_valid_i && in_ready_o;
  assign req_mode = atps_pkg::mode_e'(in_item_i.new_mode);
  // hand over once the output register is free or being emptied
  assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // current step, with a stray index read as step 0
  always_comb begin
    step_cnt = atps_pkg::step_count_f(mode_q);
    idx_eff  = (idx_q >= step_cnt) ? '0 : idx_q;
    step     = atps_pkg::step_f(mode_q, idx_eff);
    idx_next = (idx_eff + 3'd1 >= step_cnt) ? '0 : idx_eff + 3'd1;
    case (step.tone)
      atps_pkg::TONE_DRY_HIGH: freq = freq_dry_high_q;
      atps_pkg::TONE_DRY_LOW:  freq = freq_dry_low_q;
      atps_pkg::TONE_RAIN:     freq = freq_rain_q;
      atps_pkg::TONE_LINK:     freq = freq_link_q;
      default:                 freq = '0;
    endcase
  end

  always_comb begin
    mode_d   = mode_q;
    idx_d    = idx_q;
    rem_d    = rem_q;
    res_d    = '0;
    need_div = 1'b0;
    rem_load = rem_q;
    case (atps_pkg::req_e'(in_item_i.req_type))
      atps_pkg::REQ_SET_MODE: begin
        if (req_mode != mode_q) begin
          mode_d        = req_mode;
          idx_d         = '0;
          rem_d         = '0;
          res_d.applied = attached_q && (req_mode == atps_pkg::MODE_OFF);
        end
      end
      atps_pkg::REQ_OFF: begin
        mode_d        = atps_pkg::MODE_OFF;
        idx_d         = '0;
        rem_d         = '0;
        res_d.applied = attached_q;
      end
      atps_pkg::REQ_TICK: begin
        if (attached_q) begin
          if (mode_q == atps_pkg::MODE_OFF) begin
            res_d.applied = 1'b1;
          end else begin
            if (rem_q == '0) begin
              res_d.applied = 1'b1;
              need_div      = step.on && (freq != '0);
              rem_load      = step.dur;
              idx_d         = idx_next;
            end
            rem_d = (rem_load >= TickMs) ? rem_load - TickMs : '0;
          end
        end
      end
      default: ;
    endcase
  end

  atps_div #(
    .DIVIDEND (COUNTER_HZ),
    .QW       (QuotW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept && need_div),
    .divisor_i  (freq),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // reload = max(q, 1) - 1, clamped to 16 bits; compare = half of reload, rounded up
  always_comb begin
    quo_ext  = ArrW'(quotient);
    arr_wide = (quo_ext == '0) ? '0 : quo_ext - ArrW'(1);
    arr      = (arr_wide > ArrW'(atps_pkg::RELOAD_MAX)) ? atps_pkg::RELOAD_MAX
                                                         : arr_wide[atps_pkg::FreqW-1:0];
    half_sum = ({1'b0, arr} + 17'd1) >> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      attached_q      <= 1'b1;
      freq_dry_high_q <= atps_pkg::FREQ_DRY_HIGH_RST;
      freq_dry_low_q  <= atps_pkg::FREQ_DRY_LOW_RST;
      freq_rain_q     <= atps_pkg::FREQ_RAIN_RST;
      freq_link_q     <= atps_pkg::FREQ_LINK_LOST_RST;
      mode_q          <= atps_pkg::MODE_OFF;
      idx_q           <= '0;
      rem_q           <= '0;
      res_q           <= '0;
      out_q           <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (atps_pkg::cfg_reg_e'(cfg_idx_i))
          atps_pkg::CFG_ATTACHED:       attached_q      <= cfg_wdata_i[0];
          atps_pkg::CFG_FREQ_DRY_HIGH:  freq_dry_high_q <= cfg_wdata_i;
          atps_pkg::CFG_FREQ_DRY_LOW:   freq_dry_low_q  <= cfg_wdata_i;
          atps_pkg::CFG_FREQ_RAIN:      freq_rain_q     <= cfg_wdata_i;
          atps_pkg::CFG_FREQ_LINK_LOST: freq_link_q     <= cfg_wdata_i;
          default: ;
        endcase
      end

      if (load_out) begin
        out_q       <= res_q;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            mode_q  <= mode_d;
            idx_q   <= idx_d;
            rem_q   <= rem_d;
            res_q   <= res_d;
            state_q <= need_div ? ST_DIV : ST_DONE;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            res_q.sound_on      <= 1'b1;
            res_q.reload_value  <= arr;
            res_q.compare_value <= half_sum[atps_pkg::FreqW-1:0];
            state_q             <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

FILE: rtl/core/atps_chk.sv
// port-level checker of the alert tone pattern sequencer, bound to the top level
// depends on atps_pkg for the item types
`timescale 1ns / 1ps

module atps_chk (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input atps_pkg::out_item_t  out_item_o
);

  // a stalled result item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result item changed while stalled");

  // the block never takes a new item while it is still working on one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item accepted before the first was finished");

  // a result that is not a tone carries zero reload and compare
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.sound_on |->
      out_item_o.reload_value == '0 && out_item_o.compare_value == '0)
    else $error("silent result with nonzero timer values");

  // a tone is always applied and its compare is half its reload value, rounded up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.sound_on |->
      out_item_o.applied &&
      out_item_o.compare_value ==
        16'(({1'b0, out_item_o.reload_value} + 17'd1) >> 1))
    else $error("tone result with inconsistent compare value");

endmodule

bind alert_tone_pattern_sequencer atps_chk u_atps_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

FILE: verif/tb_top.sv
// self-checking testbench for the alert tone pattern sequencer: directed table, then random items
// predicts every pwm update from its own copy of the step patterns; depends on atps_pkg and the rtl
`timescale 1ns / 1ps

module tb_top;
  import atps_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 800000;
  localparam int unsigned DRAIN_CYCLES = 30;
  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned CFG_EVERY    = 400;
  localparam int unsigned LONG_HOLD    = 300;
  localparam logic [1:0]  REQ_UNUSED   = 2'd3;

  typedef struct packed {
    logic      known;
    out_item_t want;
  } fixed_exp_t;

  typedef struct {
    bit               is_cfg;
    cfg_reg_e         cfg_sel;
    logic [FreqW-1:0] cfg_val;
    in_item_t         item;
    int unsigned      reps;
    bit               known;
    out_item_t        want;
  } plan_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  in_item_t         in_item_i;
  logic             out_valid_o;
  logic             out_ready_i;
  out_item_t        out_item_o;
  logic             cfg_we_i;
  logic [2:0]       cfg_idx_i;
  logic [FreqW-1:0] cfg_wdata_i;

  // predictor copy of the block state and registers
  logic             model_attached;
  logic [FreqW-1:0] tone_hz [0:4];
  mode_e            seq_mode;
  logic [IdxW-1:0]  seq_idx;
  logic [DurW-1:0]  seq_left_ms;

  out_item_t  pwm_expect_q [$];
  fixed_exp_t hand_exp_q [$];
  plan_row_t  plan_q [$];
  int unsigned items_sent;
  int unsigned mismatch_cnt;

  alert_tone_pattern_sequencer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic out_item_t pwm_res(logic a, logic s, logic [15:0] rl, logic [15:0] cmp);
    out_item_t r;
    r.applied = a;
    r.sound_on = s;
    r.reload_value = rl;
    r.compare_value = cmp;
    return r;
  endfunction

  function automatic void pattern_step(input mode_e m, input logic [IdxW-1:0] i,
                                       output logic [DurW-1:0] dur, output tone_e tone);
    tone = TONE_NONE;
    case (m)
      MODE_DRY: begin
        dur = (i[0]) ? 10'd60 : 10'd120;
        if (i == 3'd0) tone = TONE_DRY_HIGH;
        else if (i == 3'd2) tone = TONE_DRY_LOW;
      end
      MODE_RAIN: begin
        dur = (i == 3'd5) ? 10'd400 : 10'd80;
        if (!i[0]) tone = TONE_RAIN;
      end
      MODE_LINK: begin
        dur = (i == 3'd0) ? 10'd200 : 10'd800;
        if (i == 3'd0) tone = TONE_LINK;
      end
      default: dur = '0;
    endcase
  endfunction

  function automatic out_item_t pwm_update(logic on, logic [FreqW-1:0] hz);
    out_item_t r;
    int unsigned div;
    r = '0;
    if (!model_attached) return r;
    r.applied = 1'b1;
    if (on && hz != 0) begin
      div = COUNTER_HZ_DEF / hz;
      if (div == 0) div = 1;
      div = div - 1;
      if (div > 65535) div = 65535;
      r.sound_on = 1'b1;
      r.reload_value = div[15:0];
      r.compare_value = 16'((div + 1) / 2);
    end
    return r;
  endfunction

  // advances the predictor by one item and returns the pwm update it causes
  function automatic out_item_t buzzer_next(in_item_t it);
    out_item_t r;
    int unsigned len;
    logic [DurW-1:0] dur;
    tone_e tone;
    r = '0;
    case (it.req_type)
      REQ_SET_MODE: begin
        if (mode_e'(it.new_mode) != seq_mode) begin
          seq_mode = mode_e'(it.new_mode);
          seq_idx = '0;
          seq_left_ms = '0;
          if (seq_mode == MODE_OFF) r = pwm_update(1'b0, '0);
        end
      end
      REQ_OFF: begin
        seq_mode = MODE_OFF;
        seq_idx = '0;
        seq_left_ms = '0;
        r = pwm_update(1'b0, '0);
      end
      REQ_TICK: begin
        if (model_attached) begin
          if (seq_mode == MODE_OFF) begin
            r = pwm_update(1'b0, '0);
          end else begin
            case (seq_mode)
              MODE_DRY:  len = 4;
              MODE_RAIN: len = 6;
              default:   len = 2;
            endcase
            if (seq_left_ms == 0) begin
              // an index past the pattern end reads as the first step
              if (seq_idx >= len) seq_idx = '0;
              pattern_step(seq_mode, seq_idx, dur, tone);
              r = pwm_update(tone != TONE_NONE, tone_hz[tone]);
              seq_left_ms = dur;
              seq_idx = seq_idx + 1'b1;
              if (seq_idx >= len) seq_idx = '0;
            end
            if (seq_left_ms >= TICK_MS_DEF) seq_left_ms = seq_left_ms - DurW'(TICK_MS_DEF);
            else seq_left_ms = '0;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void model_cfg(logic [2:0] idx, logic [FreqW-1:0] d);
    case (cfg_reg_e'(idx))
      CFG_ATTACHED:       model_attached = d[0];
      CFG_FREQ_DRY_HIGH:  tone_hz[TONE_DRY_HIGH] = d;
      CFG_FREQ_DRY_LOW:   tone_hz[TONE_DRY_LOW] = d;
      CFG_FREQ_RAIN:      tone_hz[TONE_RAIN] = d;
      CFG_FREQ_LINK_LOST: tone_hz[TONE_LINK] = d;
      default: ;
    endcase
  endfunction

  always @(posedge clk_i) begin : scoreboard
    out_item_t want;
    out_item_t got;
    fixed_exp_t fx;
    bit bad;
    if (rst_ni) begin
      if (cfg_we_i) model_cfg(cfg_idx_i, cfg_wdata_i);
      if (in_valid_i && in_ready_o) begin
        want = buzzer_next(in_item_i);
        if (hand_exp_q.size() != 0) begin
          fx = hand_exp_q.pop_front();
          if (fx.known) want = fx.want;
        end
        pwm_expect_q.push_back(want);
      end
      if (out_valid_o && out_ready_i) begin
        got = out_item_o;
        if (pwm_expect_q.size() == 0) begin
          $display("%0t: result %h with nothing expected", $time, got);
          mismatch_cnt++;
        end else begin
          want = pwm_expect_q.pop_front();
          bad = 0;
          if (got.applied !== want.applied) begin
            $display("%0t: applied expected %0d, got %0d", $time, want.applied, got.applied);
            bad = 1;
          end
          if (got.sound_on !== want.sound_on) begin
            $display("%0t: sound_on expected %0d, got %0d", $time, want.sound_on, got.sound_on);
            bad = 1;
          end
          if (got.reload_value !== want.reload_value) begin
            $display("%0t: reload_value expected %0d, got %0d", $time, want.reload_value,
                     got.reload_value);
            bad = 1;
          end
          if (got.compare_value !== want.compare_value) begin
            $display("%0t: compare_value expected %0d, got %0d", $time, want.compare_value,
                     got.compare_value);
            bad = 1;
          end
          if (bad) mismatch_cnt++;
        end
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [FreqW-1:0] pick_hz();
    logic [FreqW-1:0] corner [6] = '{16'd1, 16'd15, 16'd16, 16'd31, 16'hFFFE, 16'hFFFF};
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 25) return corner[$urandom_range(0, 5)];
    if (r < 70) return FreqW'($urandom_range(200, 5000));
    return FreqW'($urandom);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic push_item(in_item_t it, bit known, out_item_t want);
    int unsigned gap;
    gap = pick_gap();
    hand_exp_q.push_back('{known: known, want: want});
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    if (it.req_type != REQ_UNUSED) items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send(logic [1:0] req, logic [1:0] mode);
    push_item('{req_type: req, new_mode: mode}, 1'b0, '0);
  endtask

  // registers change only with nothing in flight
  task automatic write_reg(cfg_reg_e sel, logic [FreqW-1:0] d);
    in_valid_i <= 1'b0;
    while (pwm_expect_q.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= sel;
    cfg_wdata_i <= d;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_cfg();
    logic [FreqW-1:0] v;
    v = FreqW'($urandom);
    v[0] = ($urandom_range(0, 99) < 85);
    write_reg(CFG_ATTACHED, v);
    write_reg(CFG_FREQ_DRY_HIGH, pick_hz());
    write_reg(CFG_FREQ_DRY_LOW, pick_hz());
    write_reg(CFG_FREQ_RAIN, pick_hz());
    write_reg(CFG_FREQ_LINK_LOST, pick_hz());
  endtask

  task automatic add_item(logic [1:0] req, logic [1:0] mode, int unsigned reps, bit known,
                          out_item_t want);
    plan_row_t row;
    row = '{is_cfg: 0, cfg_sel: CFG_ATTACHED, cfg_val: '0, item: '{req, mode}, reps: reps,
            known: known, want: want};
    plan_q.push_back(row);
  endtask

  task automatic add_cfg(cfg_reg_e sel, logic [FreqW-1:0] d);
    plan_row_t row;
    row = '{is_cfg: 1, cfg_sel: sel, cfg_val: d, item: '0, reps: 0, known: 0, want: '0};
    plan_q.push_back(row);
  endtask

  initial begin : stimulus
    out_item_t none;
    out_item_t silent;
    int unsigned r;
    int unsigned n;
    int unsigned next_cfg;
    in_valid_i = 1'b0;
    in_item_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    rst_ni = 1'b0;
    items_sent = 0;
    mismatch_cnt = 0;
    model_attached = 1'b1;
    tone_hz[TONE_NONE] = '0;
    tone_hz[TONE_DRY_HIGH] = FREQ_DRY_HIGH_RST;
    tone_hz[TONE_DRY_LOW] = FREQ_DRY_LOW_RST;
    tone_hz[TONE_RAIN] = FREQ_RAIN_RST;
    tone_hz[TONE_LINK] = FREQ_LINK_LOST_RST;
    seq_mode = MODE_OFF;
    seq_idx = '0;
    seq_left_ms = '0;

    none = '0;
    silent = pwm_res(1'b1, 1'b0, '0, '0);
    // reset registers: tone values read straight off the frequencies
    add_item(REQ_TICK, MODE_OFF, 1, 1, silent);
    add_item(REQ_SET_MODE, MODE_OFF, 1, 1, none);
    add_item(REQ_UNUSED, MODE_LINK, 1, 1, none);
    add_item(REQ_SET_MODE, MODE_DRY, 1, 1, none);
    add_item(REQ_TICK, MODE_LINK, 1, 1, pwm_res(1'b1, 1'b1, 16'd399, 16'd200));
    add_item(REQ_TICK, MODE_OFF, 1, 0, none);
    add_item(REQ_SET_MODE, MODE_RAIN, 1, 1, none);
    add_item(REQ_TICK, MODE_RAIN, 1, 1, pwm_res(1'b1, 1'b1, 16'd499, 16'd250));
    add_item(REQ_SET_MODE, MODE_LINK, 1, 1, none);
    add_item(REQ_TICK, MODE_DRY, 1, 1, pwm_res(1'b1, 1'b1, 16'd665, 16'd333));
    add_item(REQ_OFF, MODE_LINK, 1, 1, silent);
    add_item(REQ_SET_MODE, MODE_RAIN, 2, 1, none);
    add_item(REQ_SET_MODE, MODE_OFF, 1, 1, silent);
    // frequency extremes: clamped reload, zero means silent
    add_cfg(CFG_FREQ_DRY_HIGH, 16'd1);
    add_cfg(CFG_FREQ_DRY_LOW, 16'hFFFF);
    add_cfg(CFG_FREQ_RAIN, 16'd0);
    add_cfg(CFG_FREQ_LINK_LOST, 16'd16);
    add_item(REQ_SET_MODE, MODE_DRY, 1, 1, none);
    add_item(REQ_TICK, MODE_OFF, 1, 1, pwm_res(1'b1, 1'b1, 16'hFFFF, 16'd32768));
    add_item(REQ_SET_MODE, MODE_RAIN, 1, 1, none);
    add_item(REQ_TICK, MODE_OFF, 1, 1, silent);
    add_item(REQ_SET_MODE, MODE_LINK, 1, 1, none);
    add_item(REQ_TICK, MODE_OFF, 1, 1, pwm_res(1'b1, 1'b1, 16'd62499, 16'd31250));
    // detached timer: nothing applied, mode changes still land
    add_cfg(CFG_ATTACHED, 16'd0);
    add_item(REQ_TICK, MODE_OFF, 1, 1, none);
    add_item(REQ_SET_MODE, MODE_DRY, 1, 1, none);
    add_item(REQ_OFF, MODE_RAIN, 1, 1, none);
    add_item(REQ_SET_MODE, MODE_LINK, 1, 1, none);
    add_item(REQ_TICK, MODE_OFF, 1, 1, none);
    add_cfg(CFG_ATTACHED, 16'd1);
    add_item(REQ_TICK, MODE_OFF, 1, 1, pwm_res(1'b1, 1'b1, 16'd62499, 16'd31250));

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan_q[k]) begin
      if (plan_q[k].is_cfg) write_reg(plan_q[k].cfg_sel, plan_q[k].cfg_val);
      else repeat (plan_q[k].reps) push_item(plan_q[k].item, plan_q[k].known, plan_q[k].want);
    end

    next_cfg = items_sent + CFG_EVERY;
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent >= next_cfg) begin
        random_cfg();
        next_cfg += CFG_EVERY;
      end
      r = $urandom_range(0, 99);
      if (r < 50) begin
        // a mode change followed by a run of ticks, at times long enough to walk a whole pattern
        send(REQ_SET_MODE, 2'($urandom_range(0, 3)));
        n = ($urandom_range(0, 9) < 8) ? $urandom_range(5, 40) : $urandom_range(60, 130);
        repeat (n) send(REQ_TICK, 2'($urandom));
      end else if (r < 65) begin
        repeat ($urandom_range(1, 20)) send(REQ_TICK, 2'($urandom));
      end else if (r < 77) begin
        send(REQ_OFF, 2'($urandom));
      end else if (r < 87) begin
        send(REQ_SET_MODE, 2'($urandom));
      end else if (r < 93) begin
        send(REQ_UNUSED, 2'($urandom));
      end else begin
        send(2'($urandom), 2'($urandom));
      end
    end

    in_valid_i <= 1'b0;
    while (pwm_expect_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (pwm_expect_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pwm_expect_q.size());
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned r;
    int unsigned hold;
    bit held_long;
    held_long = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held_long && items_sent >= 600) begin
        // long stall so the block fills up and stops taking items
        held_long = 1;
        out_ready_i <= 1'b0;
        hold = LONG_HOLD;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_ready_i <= 1'b1;
          hold = $urandom_range(1, 20);
        end else if (r < 92) begin
          out_ready_i <= 1'b0;
          hold = $urandom_range(1, 3);
        end else begin
          out_ready_i <= 1'b0;
          hold = $urandom_range(10, 40);
        end
      end
      repeat (hold) @(negedge clk_i);
    end
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("%0t: run did not finish in %0d cycles", $time, LIMIT_CYCLES);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
